// ----- design/bql_pkg.sv -----
// Shared types and constants for the multichannel biquad low-pass core.
// Used by the register block, the controller, the datapath and the top level.
package bql_pkg;

    // Field and state widths.
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int STATE_BITS   = 48;
    localparam int MAX_CHANNELS = 8;
    localparam int CH_BITS      = 3;
    localparam int CNT_BITS     = 4;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int STEP_BITS    = 3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_B0    = 3'd0;
    localparam logic [2:0] REG_B1    = 3'd1;
    localparam logic [2:0] REG_B2    = 3'd2;
    localparam logic [2:0] REG_A1    = 3'd3;
    localparam logic [2:0] REG_A2    = 3'd4;
    localparam logic [2:0] REG_COUNT = 3'd5;

    // Register reset values.
    localparam logic signed [COEF_BITS-1:0] B0_RESET    = 32'sh1000_0000;
    localparam logic [CNT_BITS-1:0]         COUNT_RESET = 4'd1;

    // Sequencer steps, named by the product issued to the shared multiplier.
    localparam logic [STEP_BITS-1:0] STEP_MUL_B0X  = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_MUL_B1X  = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_MUL_A1LO = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_MUL_A1HI = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_MUL_A2LO = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_MUL_A2HI = 3'd5;
    localparam logic [STEP_BITS-1:0] STEP_MUL_B2X  = 3'd6;
    localparam logic [STEP_BITS-1:0] STEP_FINISH   = 3'd7;

    // Filter coefficients, Q3.28.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 run;
        logic [STEP_BITS-1:0] step;
        logic                 finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ----- design/multichannel_biquad_lowpass_core.sv -----
// Each accepted beat steps through the products, then a final step loads the output register.
// The core takes one input beat at a time; seven products share one 32x25 multiplier, one a cycle.
// A result waiting on a stalled output holds the final step until the register frees.
// Reset (rst_n, async, active low): coefficients to pass-through, channel count to one,
// all delay states and the channel position to zero, no result pending.
module multichannel_biquad_lowpass_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bql_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [bql_pkg::DATA_BITS-1:0]          pwdata,
    output logic [bql_pkg::DATA_BITS-1:0]          prdata,
    output logic                                   pready,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [bql_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   start_of_stream,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [bql_pkg::SAMPLE_BITS-1:0] filtered_sample,
    output logic [bql_pkg::CH_BITS-1:0]            channel_index
);
    import bql_pkg::*;

    coef_t               coef;
    logic [CNT_BITS-1:0] channel_count;
    dp_cmd_t             cmd;
    dp_stat_t            stat;

    // Configuration registers.
    bql_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .coef          (coef),
        .channel_count (channel_count)
    );

    // Sequencer.
    bql_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Arithmetic and state.
    bql_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .coef            (coef),
        .channel_count   (channel_count),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered_sample (filtered_sample),
        .channel_index   (channel_index)
    );

endmodule

// ----- design/bql_regs.sv -----
// Configuration registers behind an APB-style port.
// Depends on bql_pkg for the register indexes, widths and coefficient type.
module bql_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bql_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [bql_pkg::DATA_BITS-1:0]  pwdata,
    output logic [bql_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output bql_pkg::coef_t                 coef,
    output logic [bql_pkg::CNT_BITS-1:0]   channel_count
);
    import bql_pkg::*;

    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [CNT_BITS-1:0]         count_reg;
    logic                        wr_en;
    logic [2:0]                  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg    <= B0_RESET;
            b1_reg    <= '0;
            b2_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            count_reg <= COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_B0:    b0_reg    <= pwdata;
                REG_B1:    b1_reg    <= pwdata;
                REG_B2:    b2_reg    <= pwdata;
                REG_A1:    a1_reg    <= pwdata;
                REG_A2:    a2_reg    <= pwdata;
                REG_COUNT: count_reg <= pwdata[CNT_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_index)
            REG_B0:    prdata = b0_reg;
            REG_B1:    prdata = b1_reg;
            REG_B2:    prdata = b2_reg;
            REG_A1:    prdata = a1_reg;
            REG_A2:    prdata = a2_reg;
            REG_COUNT: prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, count_reg};
            default:   prdata = '0;
        endcase
    end

    assign coef.b0       = b0_reg;
    assign coef.b1       = b1_reg;
    assign coef.b2       = b2_reg;
    assign coef.a1       = a1_reg;
    assign coef.a2       = a2_reg;
    assign channel_count = count_reg;

endmodule

// ----- design/bql_ctrl.sv -----
// Sequencer for the biquad core: accepts a beat and steps the shared multiplier.
// Depends on bql_pkg for the step codes and the command and status structs.
module bql_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output bql_pkg::dp_cmd_t  cmd,
    input  bql_pkg::dp_stat_t stat
);
    import bql_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 accept;
    logic                 finish;

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid & (state_reg == ST_IDLE);
    assign finish       = (state_reg == ST_RUN) && (step_reg == STEP_FINISH) && stat.out_free;

    // Next state: one step per cycle, the last step waits for a free output register.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_MUL_B0X;
                end
            end
            ST_RUN:
            begin
                if (step_reg != STEP_FINISH)
                begin
                    step_next = step_reg + 3'd1;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_MUL_B0X;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign cmd.load   = accept;
    assign cmd.run    = (state_reg == ST_RUN);
    assign cmd.step   = step_reg;
    assign cmd.finish = finish;

endmodule

// ----- design/bql_dp.sv -----
// Datapath of the biquad core: shared multiplier, accumulators, delay states,
// channel position and the output register. Depends on bql_pkg.
module bql_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bql_pkg::dp_cmd_t                    cmd,
    output bql_pkg::dp_stat_t                   stat,
    input  bql_pkg::coef_t                      coef,
    input  logic [bql_pkg::CNT_BITS-1:0]        channel_count,
    input  logic signed [bql_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                start_of_stream,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [bql_pkg::SAMPLE_BITS-1:0] filtered_sample,
    output logic [bql_pkg::CH_BITS-1:0]         channel_index
);
    import bql_pkg::*;

    localparam int MUL_B_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS  = COEF_BITS + MUL_B_BITS;
    localparam int FB_BITS    = PROD_BITS + 1;
    localparam int Q_BITS     = FB_BITS - 24;
    localparam int RND_BITS   = STATE_BITS + 1;

    // Item registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CH_BITS-1:0]            ch_reg;
    logic [CH_BITS-1:0]            pos_reg;
    logic signed [STATE_BITS-1:0]  y_reg, t1_reg, t2_reg;
    logic signed [Q_BITS-1:0]      q_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;

    // Per-channel delay states.
    logic signed [STATE_BITS-1:0]  z1_reg [MAX_CHANNELS];
    logic signed [STATE_BITS-1:0]  z2_reg [MAX_CHANNELS];

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [CH_BITS-1:0]            out_ch_reg;

    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   prod_full;
    logic signed [PROD_BITS-1:0]   rnd_sum;
    logic signed [PROD_BITS-1:0]   rnd_shift;
    logic signed [STATE_BITS-1:0]  rnd_in;
    logic signed [FB_BITS-1:0]     prod_ext;
    logic signed [FB_BITS-1:0]     lo_sum;
    logic signed [FB_BITS-1:0]     lo_shift;
    logic signed [FB_BITS-1:0]     fb_sum;
    logic signed [FB_BITS-1:0]     fb_shift;
    logic signed [STATE_BITS-1:0]  fb;
    logic signed [RND_BITS-1:0]    out_sum;
    logic signed [RND_BITS-1:0]    out_shift;
    logic signed [SAMPLE_BITS-1:0] out_sat;
    logic [CNT_BITS-1:0]           count_eff;
    logic [CH_BITS-1:0]            ch_new;
    logic [CNT_BITS-1:0]           ch_inc;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.step)
            STEP_MUL_B0X:
            begin
                mul_a = coef.b0;
                mul_b = {x_reg[SAMPLE_BITS-1], x_reg};
            end
            STEP_MUL_B1X:
            begin
                mul_a = coef.b1;
                mul_b = {x_reg[SAMPLE_BITS-1], x_reg};
            end
            STEP_MUL_A1LO:
            begin
                mul_a = coef.a1;
                mul_b = {1'b0, y_reg[23:0]};
            end
            STEP_MUL_A1HI:
            begin
                mul_a = coef.a1;
                mul_b = {y_reg[STATE_BITS-1], y_reg[STATE_BITS-1:24]};
            end
            STEP_MUL_A2LO:
            begin
                mul_a = coef.a2;
                mul_b = {1'b0, y_reg[23:0]};
            end
            STEP_MUL_A2HI:
            begin
                mul_a = coef.a2;
                mul_b = {y_reg[STATE_BITS-1], y_reg[STATE_BITS-1:24]};
            end
            STEP_MUL_B2X:
            begin
                mul_a = coef.b2;
                mul_b = {x_reg[SAMPLE_BITS-1], x_reg};
            end
            default:
            begin
                mul_a = coef.b0;
                mul_b = {x_reg[SAMPLE_BITS-1], x_reg};
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Input-path rounding: Q4.51 product to Q8.40, round half up.
    assign rnd_sum   = prod_reg + PROD_BITS'(1024);
    assign rnd_shift = rnd_sum >>> 11;
    assign rnd_in    = rnd_shift[STATE_BITS-1:0];

    // Feedback rounding over the split product: low half first, then high half.
    assign prod_ext = {prod_reg[PROD_BITS-1], prod_reg};
    assign lo_sum   = prod_ext + FB_BITS'(134217728);
    assign lo_shift = lo_sum >>> 24;
    assign fb_sum   = prod_ext + {{(FB_BITS-Q_BITS){q_reg[Q_BITS-1]}}, q_reg};
    assign fb_shift = fb_sum >>> 4;
    assign fb       = fb_shift[STATE_BITS-1:0];

    // Output rounding to Q1.23 with saturation.
    assign out_sum   = {y_reg[STATE_BITS-1], y_reg} + RND_BITS'(65536);
    assign out_shift = out_sum >>> 17;
    always_comb
    begin
        if (out_shift[RND_BITS-1:SAMPLE_BITS-1] == '0 ||
            out_shift[RND_BITS-1:SAMPLE_BITS-1] == '1)
        begin
            out_sat = out_shift[SAMPLE_BITS-1:0];
        end
        else if (out_shift[RND_BITS-1])
        begin
            out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Channel rotation with the count clamped to 1..MAX_CHANNELS.
    always_comb
    begin
        if (channel_count == '0)
        begin
            count_eff = CNT_BITS'(1);
        end
        else if (channel_count > CNT_BITS'(MAX_CHANNELS))
        begin
            count_eff = CNT_BITS'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = channel_count;
        end
    end
    assign ch_new = start_of_stream ? '0 : pos_reg;
    assign ch_inc = {1'b0, ch_new} + CNT_BITS'(1);

    // Control state: position, delay states, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= (ch_inc >= count_eff) ? '0 : ch_inc[CH_BITS-1:0];
                if (start_of_stream)
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                    begin
                        z1_reg[i] <= '0;
                        z2_reg[i] <= '0;
                    end
                end
            end
            if (cmd.finish)
            begin
                z1_reg[ch_reg] <= t1_reg;
                z2_reg[ch_reg] <= t2_reg + rnd_in;
                out_valid_reg  <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: sample latch, product and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= sample;
            ch_reg <= ch_new;
        end
        if (cmd.run && cmd.step != STEP_FINISH)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.run)
        begin
            case (cmd.step)
                STEP_MUL_B1X:  y_reg  <= rnd_in + z1_reg[ch_reg];
                STEP_MUL_A1LO: t1_reg <= rnd_in + z2_reg[ch_reg];
                STEP_MUL_A1HI: q_reg  <= lo_shift[Q_BITS-1:0];
                STEP_MUL_A2LO: t1_reg <= t1_reg - fb;
                STEP_MUL_A2HI: q_reg  <= lo_shift[Q_BITS-1:0];
                STEP_MUL_B2X:  t2_reg <= -fb;
                default:       ;
            endcase
        end
        if (cmd.finish)
        begin
            out_sample_reg <= out_sat;
            out_ch_reg     <= ch_reg;
        end
    end

    assign stat.out_free   = !out_valid_reg || !result_stall;
    assign result_valid    = out_valid_reg;
    assign filtered_sample = out_sample_reg;
    assign channel_index   = out_ch_reg;

endmodule

// ----- design/bql_checker.sv -----
// Port-level checks for the biquad core, attached to the top level by bind.
// Depends on bql_pkg for field widths.
module bql_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   pready,
    input logic                                   sample_valid,
    input logic                                   sample_stall,
    input logic                                   result_valid,
    input logic                                   result_stall,
    input logic signed [bql_pkg::SAMPLE_BITS-1:0] filtered_sample,
    input logic [bql_pkg::CH_BITS-1:0]            channel_index
);
    import bql_pkg::*;

    // The core takes one beat at a time, so it stalls right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("input not stalled after an accepted beat");

    // A new result only comes out of a busy core.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared without work in progress");

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result payload holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> ($stable(filtered_sample) && $stable(channel_index)))
        else $error("result payload changed while stalled");

endmodule

bind multichannel_biquad_lowpass_core bql_checker u_bql_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .filtered_sample (filtered_sample),
    .channel_index   (channel_index)
);

// ----- tb/sv/multichannel_biquad_lowpass_core_tb.sv -----
// Self-checking testbench for the multichannel biquad low-pass core.
// Depends on bql_pkg and multichannel_biquad_lowpass_core; predicts every result beat in SV.
`timescale 1ns / 1ps

module multichannel_biquad_lowpass_core_tb;
    import bql_pkg::*;

    localparam int          LATENCY      = 9;
    localparam int          LONG_HOLD    = 300;
    localparam int          NUM_PHASES   = 12;
    localparam int          PHASE_BEATS  = 70;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam logic [2:0]  REG_UNUSED_A = 3'd6;
    localparam logic [2:0]  REG_UNUSED_B = 3'd7;

    // One result beat: the filtered sample and the channel it came from.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_BITS-1:0]            ch;
    } audio_out_t;

    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    // One row of the directed table: a register write or a sample beat.
    typedef struct packed {
        row_kind_t                     kind;
        logic [2:0]                    idx;
        logic [DATA_BITS-1:0]          data;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          sos;
        logic                          typed;
        audio_out_t                    want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_BITS-1:0]          paddr;
    logic [DATA_BITS-1:0]          pwdata;
    logic [DATA_BITS-1:0]          prdata;
    logic                          pready;
    logic                          sample_valid;
    logic                          sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_stream;
    logic                          result_valid;
    logic                          result_stall;
    logic signed [SAMPLE_BITS-1:0] filtered_sample;
    logic [CH_BITS-1:0]            channel_index;

    // Expected value travels with the beat when it is typed into the table.
    logic                          beat_typed;
    audio_out_t                    beat_expect;

    // Shadow of the filter: coefficients, channel count, delay lines, position.
    logic signed [COEF_BITS-1:0]   coef_shadow [5];
    logic [CNT_BITS-1:0]           count_shadow;
    longint                        delay_z1 [MAX_CHANNELS];
    longint                        delay_z2 [MAX_CHANNELS];
    logic [CH_BITS-1:0]            chan_pos;

    audio_out_t                    filtered_due [$];
    int                            mismatches;
    int unsigned                   cycle_count;
    logic                          idle_on;
    logic                          hold_request;

    multichannel_biquad_lowpass_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered_sample (filtered_sample),
        .channel_index   (channel_index)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sign-extend the low 48 bits, as the delay registers wrap.
    function automatic longint wrap48(input longint v);
        logic [STATE_BITS-1:0] t;
        t = v[STATE_BITS-1:0];
        return {{(64-STATE_BITS){t[STATE_BITS-1]}}, t};
    endfunction

    // Coefficient times input sample, Q4.51 rounded half up to Q8.40.
    function automatic longint scale_input(input longint c, input longint x);
        longint p;
        p = c * x + 64'sd1024;
        return p >>> 11;
    endfunction

    // Coefficient times Q8.40 output, split in two halves to stay inside 64 bits.
    function automatic longint scale_feedback(input longint c, input longint y);
        longint lo;
        longint hi;
        longint plo;
        longint phi;
        lo  = y & 64'h0000_0000_00FF_FFFF;
        hi  = y >>> 24;
        plo = c * lo + 64'sd134217728;
        phi = c * hi;
        return (phi + (plo >>> 24)) >>> 4;
    endfunction

    // One step of the transposed direct form II section on the shadow state.
    function automatic void run_biquad(input logic signed [SAMPLE_BITS-1:0] x_in,
                                       input logic sos, output audio_out_t res);
        longint             x;
        longint             y;
        longint             o;
        int                 n;
        logic [CH_BITS-1:0] ch;
        x = x_in;
        n = count_shadow;
        if (n < 1)
            n = 1;
        if (n > MAX_CHANNELS)
            n = MAX_CHANNELS;
        if (sos)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                delay_z1[i] = 0;
                delay_z2[i] = 0;
            end
            chan_pos = '0;
        end
        ch = chan_pos;
        y = wrap48(scale_input(coef_shadow[REG_B0], x) + delay_z1[ch]);
        delay_z1[ch] = wrap48(scale_input(coef_shadow[REG_B1], x)
                              - scale_feedback(coef_shadow[REG_A1], y) + delay_z2[ch]);
        delay_z2[ch] = wrap48(scale_input(coef_shadow[REG_B2], x)
                              - scale_feedback(coef_shadow[REG_A2], y));
        o = (y + 64'sd65536) >>> 17;
        if (o > 64'sd8388607)
            o = 64'sd8388607;
        if (o < -64'sd8388608)
            o = -64'sd8388608;
        res.smp = o[SAMPLE_BITS-1:0];
        res.ch  = ch;
        // A position left beyond a reduced count is used once, then wraps to zero.
        chan_pos = (ch + 1 >= n) ? '0 : ch + 1'b1;
    endfunction

    // Predict on every accepted input beat, check every accepted result beat.
    always @(posedge clk)
    begin
        audio_out_t pred;
        audio_out_t got;
        audio_out_t want;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                run_biquad(sample, start_of_stream, pred);
                if (beat_typed)
                    filtered_due.push_back(beat_expect);
                else
                    filtered_due.push_back(pred);
            end
            if (result_valid && !result_stall)
            begin
                got.smp = filtered_sample;
                got.ch  = channel_index;
                if (filtered_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result beat with nothing expected: sample %0d ch %0d",
                                 $realtime, got.smp, got.ch);
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (got.smp !== want.smp || got.ch !== want.ch)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: expected sample %0d ch %0d, got %0d ch %0d",
                                     $realtime, want.smp, want.ch, got.smp, got.ch);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx) inside
            REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: coef_shadow[idx] = data;
            REG_COUNT: count_shadow = data[CNT_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one input beat and hold it until accepted.
    task automatic offer_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic sos,
                              input logic typed, input audio_out_t want);
        sample_valid    <= 1'b1;
        sample          <= s;
        start_of_stream <= sos;
        beat_typed      <= typed;
        beat_expect     <= want;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        sample_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every expected result beat has come back.
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (filtered_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic stim_row_t beat_row(input int s, input bit sos, input bit typed = 1'b0,
                                           input int want_s = 0, input int want_ch = 0);
        stim_row_t r;
        r        = '0;
        r.kind   = ROW_BEAT;
        r.smp    = SAMPLE_BITS'(s);
        r.sos    = sos;
        r.typed  = typed;
        r.want.smp = SAMPLE_BITS'(want_s);
        r.want.ch  = CH_BITS'(want_ch);
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [2:0] idx, input logic [31:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [DATA_BITS-1:0] extreme_coef();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h1000_0000;
            default: return 32'hF000_0000;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 24'sh7F_FFFF;
            1: return 24'sh80_0000;
            2: return SAMPLE_BITS'($signed(r[8:0]));
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // Stimulus: directed table first, then random phases with fresh settings.
    initial
    begin
        stim_row_t              directed_rows [$];
        logic [DATA_BITS-1:0]   c;
        int unsigned            mag;
        int unsigned            a2_mag;
        int                     mode;
        logic                   fresh;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_valid    = 1'b0;
        sample          = '0;
        start_of_stream = 1'b0;
        beat_typed      = 1'b0;
        beat_expect     = '0;
        mismatches      = 0;
        cycle_count     = 0;
        idle_on         = 1'b0;
        hold_request    = 1'b0;
        coef_shadow[REG_B0] = B0_RESET;
        coef_shadow[REG_B1] = '0;
        coef_shadow[REG_B2] = '0;
        coef_shadow[REG_A1] = '0;
        coef_shadow[REG_A2] = '0;
        count_shadow        = COUNT_RESET;
        chan_pos            = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            delay_z1[i] = 0;
            delay_z2[i] = 0;
        end

        // Pass-through after reset: extremes and alternating bit patterns come back as is.
        directed_rows.push_back(beat_row(0, 1'b1, 1'b1, 0, 0));
        directed_rows.push_back(beat_row(8388607, 1'b0, 1'b1, 8388607, 0));
        directed_rows.push_back(beat_row(-8388608, 1'b0, 1'b1, -8388608, 0));
        directed_rows.push_back(beat_row(5592405, 1'b0, 1'b1, 5592405, 0));
        directed_rows.push_back(beat_row(-5592406, 1'b0, 1'b1, -5592406, 0));
        // Three channels rotate.
        directed_rows.push_back(write_row(REG_COUNT, 3));
        directed_rows.push_back(beat_row(100, 1'b0, 1'b1, 100, 0));
        directed_rows.push_back(beat_row(-200, 1'b0, 1'b1, -200, 1));
        directed_rows.push_back(beat_row(300, 1'b0, 1'b1, 300, 2));
        // Largest gains saturate the output in both directions.
        directed_rows.push_back(write_row(REG_B0, 32'h7FFF_FFFF));
        directed_rows.push_back(beat_row(8388607, 1'b0, 1'b1, 8388607, 0));
        directed_rows.push_back(beat_row(-8388608, 1'b0, 1'b1, -8388608, 1));
        directed_rows.push_back(write_row(REG_B0, 32'h8000_0000));
        directed_rows.push_back(beat_row(8388607, 1'b0, 1'b1, -8388608, 2));
        directed_rows.push_back(beat_row(-8388608, 1'b0, 1'b1, 8388607, 0));
        // Count of zero acts as one; the stale position is used once, then wraps.
        directed_rows.push_back(write_row(REG_COUNT, 0));
        directed_rows.push_back(beat_row(0, 1'b0, 1'b1, 0, 1));
        directed_rows.push_back(beat_row(0, 1'b0, 1'b1, 0, 0));
        // Count above the maximum acts as eight; a real low-pass section runs.
        directed_rows.push_back(write_row(REG_COUNT, 15));
        directed_rows.push_back(write_row(REG_B0, 32'd26199300));
        directed_rows.push_back(write_row(REG_B1, 32'd52398600));
        directed_rows.push_back(write_row(REG_B2, 32'd26199300));
        directed_rows.push_back(write_row(REG_A1, -32'sd253081000));
        directed_rows.push_back(write_row(REG_A2, 32'd89469000));
        directed_rows.push_back(write_row(REG_UNUSED_A, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(REG_UNUSED_B, 32'h1234_5678));
        directed_rows.push_back(beat_row(8388607, 1'b1));
        directed_rows.push_back(beat_row(-8388608, 1'b0));
        directed_rows.push_back(beat_row(4000000, 1'b0));
        directed_rows.push_back(beat_row(-4000000, 1'b0));
        for (int i = 0; i < 5; i++)
            directed_rows.push_back(beat_row(8388607, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                drain();
                cfg_write(directed_rows[r].idx, directed_rows[r].data);
            end
            else
            begin
                offer_beat(directed_rows[r].smp, directed_rows[r].sos,
                           directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            // The last stretch of the run has no idling at all.
            idle_on = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            mode = (phase < 3) ? phase : $urandom_range(0, 3);

            for (int k = 0; k < 5; k++)
            begin
                case (mode)
                    0:
                    begin
                        // Stable section: poles kept inside the unit circle.
                        if (k < 3)
                        begin
                            mag = $urandom_range(0, 32'h0800_0000);
                            c = $urandom_range(0, 1) ? -mag : mag;
                        end
                        else if (k == 3)
                        begin
                            a2_mag = $urandom_range(0, 241591910);
                            mag = $urandom_range(0, (268435456 + a2_mag) / 20 * 19);
                            c = $urandom_range(0, 1) ? -mag : mag;
                        end
                        else
                            c = a2_mag;
                    end
                    1: c = extreme_coef();
                    default: c = $urandom;
                endcase
                // Mode three leaves the coefficient at pass-through for b0 and zero elsewhere.
                if (mode == 3)
                    c = (k == 0) ? B0_RESET : '0;
                cfg_write(k[2:0], c);
            end
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_COUNT, $urandom_range(0, 15));
            else
                cfg_write(REG_COUNT, (phase == 0) ? MAX_CHANNELS : $urandom_range(1, 8));
            if ($urandom_range(0, 3) == 0)
                cfg_write($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);

            // Receiver holds off long enough for the core to back up its input.
            if (phase == 2)
                hold_request = 1'b1;

            fresh = (phase == 0) || ($urandom_range(0, 1) == 1);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (phase == 1 && k == PHASE_BEATS / 2)
                    drain();
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 13));
                offer_beat(random_sample(),
                           (k == 0 && fresh) || ($urandom_range(0, 39) == 0),
                           1'b0, '0);
            end
        end

        drain();
        repeat (4 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
